// ===== design/lbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpr_pkg
// Field widths and the result record shared by the balanced parity run block
// and its checker.
// ----------------------------------------------------------------------------
package lbpr_pkg;

    localparam int CHAR_W     = 8;
    localparam int START_W    = 10;
    localparam int LEN_W      = 11;
    localparam int RES_W      = 1 + START_W + LEN_W + 1;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int MIN_FOUND  = 2;

    // packed from the lowest bit up: found, match_start, match_length, too_long
    typedef struct packed {
        logic               too_long;
        logic [LEN_W-1:0]   match_length;
        logic [START_W-1:0] match_start;
        logic               found;
    } t_result;

endpackage

// ===== design/longest_balanced_parity_run.sv =====
// ----------------------------------------------------------------------------
// longest_balanced_parity_run
// Finds the longest run of a byte string with as many odd as even bytes.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                          tlast
// s_axis    in   [7:0] char_byte                                last_char
// m_axis    out  [0] found, [10:1] match_start,                 -
//                [21:11] match_length, [22] too_long, [23] zero
//
// One byte per cycle, save for the stall below. A result leaves at the earliest
// once its last byte has passed the first-seen table read and the compare, each registered.
// The table needs no clearing: balances seen so far are always the contiguous
// range between the running minimum and maximum, so the block is ready right
// after reset. Reset is synchronous, active low.
// A stalled result blocks input only once the next string's last byte is
// waiting behind it.
// ----------------------------------------------------------------------------
module longest_balanced_parity_run
    import lbpr_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_byte
    input  logic                  s_axis_tlast,   // last_char
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // found, match_start, match_length, too_long
);

    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int BAL_W  = POS_W + 1;
    localparam int TBL_D  = 2 * MAX_LEN + 1;
    localparam int ADDR_W = $clog2(TBL_D);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int EXT_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

    typedef struct packed {
        logic             last;
        logic             hit;
        logic             zero;
        logic             ovf;
        logic [POS_W-1:0] pos;
    } t_s1;

    logic [POS_W-1:0]        r_first_mem [TBL_D];
    logic [POS_W-1:0]        r_rd;

    logic [POS_W-1:0]        r_pos, n_pos;
    logic signed [BAL_W-1:0] r_bal, n_bal;
    logic signed [BAL_W-1:0] r_min, n_min;
    logic signed [BAL_W-1:0] r_max, n_max;
    logic                    r_ovf, n_ovf;

    t_s1                     r_s1, n_s1;
    logic                    r_s1_valid, n_s1_valid;

    logic [POS_W-1:0]        r_best_len, n_best_len;
    logic [POS_W-1:0]        r_best_start, n_best_start;

    t_result                 r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    w_in_acc;
    logic                    w_active;
    logic signed [BAL_W-1:0] w_bal_step;
    logic [POS_W-1:0]        w_pos_inc;
    logic                    w_seen;
    logic signed [SUM_W-1:0] w_sum;
    logic [ADDR_W-1:0]       w_addr;
    logic                    w_wr;

    logic                    w_s1_adv;
    logic [POS_W-1:0]        w_first;
    logic [POS_W-1:0]        w_run;
    logic                    w_better;
    logic [POS_W-1:0]        w_res_len;
    logic [POS_W-1:0]        w_res_start;
    logic                    w_found;
    logic [EXT_W-1:0]        w_len_ext;
    logic [EXT_W-1:0]        w_start_ext;

    // ---- stage 0: balance update and table access
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_active   = r_pos < POS_W'(MAX_LEN);
    assign w_bal_step = s_axis_tdata[0] ? r_bal + BAL_W'(1) : r_bal - BAL_W'(1);
    assign w_pos_inc  = r_pos + POS_W'(1);
    assign w_seen     = (w_bal_step >= r_min) && (w_bal_step <= r_max);
    assign w_sum      = SUM_W'(w_bal_step) + SUM_W'(MAX_LEN);
    assign w_addr     = w_sum[ADDR_W-1:0];
    assign w_wr       = w_in_acc && w_active && !w_seen;

    always_comb begin
        n_pos = r_pos;
        n_bal = r_bal;
        n_min = r_min;
        n_max = r_max;
        n_ovf = r_ovf;
        if (w_in_acc) begin
            if (s_axis_tlast) begin
                n_pos = '0;
                n_bal = '0;
                n_min = '0;
                n_max = '0;
                n_ovf = 1'b0;
            end else if (w_active) begin
                n_pos = w_pos_inc;
                n_bal = w_bal_step;
                if (w_bal_step < r_min) begin
                    n_min = w_bal_step;
                end
                if (w_bal_step > r_max) begin
                    n_max = w_bal_step;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        n_s1.last = s_axis_tlast;
        n_s1.hit  = w_active && w_seen;
        n_s1.zero = (w_bal_step == '0);
        n_s1.ovf  = r_ovf || !w_active;
        n_s1.pos  = w_pos_inc;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_wr) begin
                r_first_mem[w_addr] <= w_pos_inc;
            end
            r_rd <= r_first_mem[w_addr];
        end
    end

    // ---- stage 1: run length compare and result
    assign w_s1_adv      = r_s1_valid && (!r_s1.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;

    assign w_first     = r_s1.zero ? '0 : r_rd;
    assign w_run       = r_s1.pos - w_first;
    assign w_better    = r_s1.hit && (w_run > r_best_len);
    assign w_res_len   = w_better ? w_run : r_best_len;
    assign w_res_start = w_better ? w_first : r_best_start;
    assign w_found     = w_res_len >= POS_W'(MIN_FOUND);
    assign w_len_ext   = EXT_W'(w_res_len);
    assign w_start_ext = EXT_W'(w_res_start);

    always_comb begin
        n_s1_valid   = w_in_acc ? 1'b1 : (w_s1_adv ? 1'b0 : r_s1_valid);
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !m_axis_tready;
        if (w_s1_adv) begin
            if (r_s1.last) begin
                n_best_len         = '0;
                n_best_start       = '0;
                n_out_valid        = 1'b1;
                n_out.found        = w_found;
                n_out.match_start  = w_found ? w_start_ext[START_W-1:0] : '0;
                n_out.match_length = w_found ? w_len_ext[LEN_W-1:0] : '0;
                n_out.too_long     = r_s1.ovf;
            end else begin
                n_best_len   = w_res_len;
                n_best_start = w_res_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_bal        <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_ovf        <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_bal        <= n_bal;
            r_min        <= n_min;
            r_max        <= n_max;
            r_ovf        <= n_ovf;
            r_s1_valid   <= n_s1_valid;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= n_s1;
        end
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

endmodule

// ===== design/lbpr_checker.sv =====
// ----------------------------------------------------------------------------
// lbpr_checker
// Port-level checks on the balanced parity run block, bound to its top level.
// ----------------------------------------------------------------------------
module lbpr_checker
    import lbpr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_result w_res;
    logic    w_in_last;

    assign w_res     = m_axis_tdata[RES_W-1:0];
    assign w_in_last = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.found |-> w_res.match_start == '0 && w_res.match_length == '0)
        else $error("empty result carries a run");

    a_found_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.found |-> w_res.match_length >= LEN_W'(MIN_FOUND)
            && !w_res.match_length[0])
        else $error("reported run is not balanced");

    // an idle output never waits on a stalled stage, so a result rises once its last
    // byte has passed the stage 1 register and then the output register
    a_rose_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_in_last, 2))
        else $error("result rose without a last transfer two cycles earlier");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind longest_balanced_parity_run lbpr_checker u_lbpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
